// ===== hdl/lowest_free_id_allocator_unit_assert.svh =====
// Assertion macros for the identifier allocator.
`ifndef LOWEST_FREE_ID_ALLOCATOR_UNIT_ASSERT_SVH
`define LOWEST_FREE_ID_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define LFIA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lfia: assertion failed");
// Antecedent at one edge implies consequent at the next.
`define LFIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfia: assertion failed");
`else
`define LFIA_ASSERT(label, clk, rst_n, prop)
`define LFIA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/lfia_pkg.sv =====
package lfia_pkg;

    localparam int ID_CAPACITY_DEF = 1024;
    localparam int WORD_BITS_DEF   = 32;

    localparam int CMD_W      = 2;
    localparam int TARGET_W   = 10;
    localparam int STATUS_W   = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [TARGET_W-1:0] target_id_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_GENERATE = 2'd0;
    localparam cmd_t CMD_FREE     = 2'd1;
    localparam cmd_t CMD_REGISTER = 2'd2;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_FULL = 2'd1;
    localparam status_t ST_BAD  = 2'd2;

endpackage

// ===== hdl/lfia_req_if.sv =====
interface lfia_req_if;
    import lfia_pkg::*;

    logic       valid;
    logic       ready;
    cmd_t       command;
    target_id_t target_id;

    modport source (output valid, output command, output target_id, input ready);
    modport sink   (input valid, input command, input target_id, output ready);
endinterface

// ===== hdl/lfia_rsp_if.sv =====
interface lfia_rsp_if;
    import lfia_pkg::*;

    logic       valid;
    logic       ready;
    target_id_t granted_id;
    status_t    status;

    modport source (output valid, output granted_id, output status, input ready);
    modport sink   (input valid, input granted_id, input status, output ready);
endinterface

// ===== hdl/lfia_ram.sv =====
module lfia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hdl/lowest_free_id_allocator_unit.sv =====
// Channel | Dir | Payload                      | Handshake
// req     | in  | command, target_id           | valid/ready, taken when both high
// rsp     | out | granted_id, status           | valid/ready, taken when both high
//
// One request at a time. Bad id, full and the spare code go straight to the done
// state; free, register off the hint, or a hint that goes straight to the full marker
// pass through a read-modify-write first; generate or register that moves the hint
// also scans for the next free id, at most up to the last word. The scan reads one
// word per cycle from the bitmap RAM, which is zeroed after reset, one word a cycle,
// with req.ready low. The done state loads the result register. A stalled rsp holds its
// result; a new request may still be accepted and waits for it before finishing.
`include "lowest_free_id_allocator_unit_assert.svh"

module lowest_free_id_allocator_unit #(
    parameter int ID_CAPACITY = lfia_pkg::ID_CAPACITY_DEF,
    parameter int WORD_BITS   = lfia_pkg::WORD_BITS_DEF  // power of two
) (
    input logic       clk,
    input logic       rst_n,
    lfia_req_if.sink  req,
    lfia_rsp_if.source rsp
);
    import lfia_pkg::*;

    localparam int WORD_COUNT = (ID_CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int WS         = $clog2(WORD_BITS);
    // hint must also hold ID_CAPACITY itself (the full marker)
    localparam int HINT_W     = $clog2(ID_CAPACITY + 1);
    localparam int TAIL_BITS  = WORD_COUNT * WORD_BITS - ID_CAPACITY;
    // bits of the last word that lie beyond the capacity count as used
    localparam logic [WORD_BITS-1:0] TAIL_MASK = ~({WORD_BITS{1'b1}} >> TAIL_BITS);
    localparam logic [WA_W-1:0]      LAST_WORD = WA_W'(WORD_COUNT - 1);
    localparam logic [HINT_W-1:0]    CAP_POS   = HINT_W'(ID_CAPACITY);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_MODIFY   = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CHK = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [HINT_W-1:0] hint_reg, hint_next;
    logic [WA_W-1:0]   clr_addr_reg, clr_addr_next;
    logic              out_valid_reg, out_valid_next;

    // working and result payload
    cmd_t              cmd_reg, cmd_next;
    logic [HINT_W-1:0] pos_reg, pos_next;
    logic [WA_W-1:0]   scan_word_reg, scan_word_next;
    target_id_t        res_granted_reg, res_granted_next;
    status_t           res_status_reg, res_status_next;
    target_id_t        out_granted_reg, out_granted_next;
    status_t           out_status_reg, out_status_next;

    // bitmap RAM port
    logic                 ram_we;
    logic [WA_W-1:0]      ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [WA_W-1:0]      ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    // request decode
    logic              in_bad;
    logic [HINT_W-1:0] in_pos;
    logic              hint_full;

    // modify and scan helpers
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] low_mask;
    logic [WORD_BITS-1:0] scan_masked;
    logic                 ffz_found;
    logic [WS-1:0]        ffz_idx;
    logic [HINT_W-1:0]    start_pos;

    lfia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT),
        .ADDR_W(WA_W)
    ) u_bitmap (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.granted_id = out_granted_reg;
    assign rsp.status     = out_status_reg;

    // id 0 is reserved; anything at or above capacity is out of range
    assign in_bad    = (req.target_id == '0) ||
                       ({{(32-TARGET_W){1'b0}}, req.target_id} >= 32'(ID_CAPACITY));
    assign in_pos    = HINT_W'(req.target_id);
    assign hint_full = (hint_reg == CAP_POS);

    // bit touched by the read-modify-write
    assign bit_mask  = WORD_BITS'(1) << pos_reg[WS-1:0];
    assign start_pos = pos_reg + HINT_W'(1);

    // first scanned word skips the bits at or below the modified id
    assign low_mask = (scan_word_reg == pos_reg[WS +: WA_W]) ?
                      ((WORD_BITS'(1) << pos_reg[WS-1:0]) - WORD_BITS'(1)) : '0;
    assign scan_masked = ram_rdata | low_mask |
                         ((scan_word_reg == LAST_WORD) ? TAIL_MASK : '0);
    assign ffz_found   = ~&scan_masked;

    // find first zero, lowest index wins
    always_comb
    begin
        ffz_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!scan_masked[i])
            begin
                ffz_idx = WS'(i);
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        hint_next        = hint_reg;
        clr_addr_next    = clr_addr_reg;
        out_valid_next   = out_valid_reg;
        cmd_next         = cmd_reg;
        pos_next         = pos_reg;
        scan_word_next   = scan_word_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        out_granted_next = out_granted_reg;
        out_status_next  = out_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = pos_reg[WS +: WA_W];
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = scan_word_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + WA_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next         = req.command;
                    res_granted_next = '0;
                    res_status_next  = ST_OK;
                    state_next       = S_DONE;
                    case (req.command) inside
                        CMD_GENERATE:
                        begin
                            if (hint_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                pos_next         = hint_reg;
                                res_granted_next = TARGET_W'(hint_reg);
                                ram_re           = 1'b1;
                                ram_raddr        = hint_reg[WS +: WA_W];
                                state_next       = S_MODIFY;
                            end
                        end
                        CMD_FREE, CMD_REGISTER:
                        begin
                            if (in_bad)
                            begin
                                res_status_next = ST_BAD;
                            end
                            else
                            begin
                                pos_next   = in_pos;
                                ram_re     = 1'b1;
                                ram_raddr  = in_pos[WS +: WA_W];
                                state_next = S_MODIFY;
                            end
                        end
                        default:
                        begin
                            // unused code: plain ok result
                        end
                    endcase
                end
            end

            S_MODIFY:
            begin
                ram_we     = 1'b1;
                state_next = S_DONE;
                if (cmd_reg == CMD_FREE)
                begin
                    ram_wdata = ram_rdata & ~bit_mask;
                    if (pos_reg < hint_reg)
                    begin
                        hint_next = pos_reg;
                    end
                end
                else
                begin
                    ram_wdata = ram_rdata | bit_mask;
                    if ((cmd_reg == CMD_GENERATE) || (pos_reg == hint_reg))
                    begin
                        if (start_pos == CAP_POS)
                        begin
                            hint_next = CAP_POS;
                        end
                        else
                        begin
                            pos_next       = start_pos;
                            scan_word_next = start_pos[WS +: WA_W];
                            state_next     = S_SCAN_RD;
                        end
                    end
                end
            end

            S_SCAN_RD:
            begin
                // first scan read; it follows the write, so the word written last cycle reads back updated
                ram_re     = 1'b1;
                ram_raddr  = scan_word_reg;
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (ffz_found)
                begin
                    hint_next  = HINT_W'({scan_word_reg, ffz_idx});
                    state_next = S_DONE;
                end
                else if (scan_word_reg == LAST_WORD)
                begin
                    hint_next  = CAP_POS;
                    state_next = S_DONE;
                end
                else
                begin
                    scan_word_next = scan_word_reg + WA_W'(1);
                    ram_re         = 1'b1;
                    ram_raddr      = scan_word_reg + WA_W'(1);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_status_next  = res_status_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            hint_reg      <= HINT_W'(1);
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        pos_reg         <= pos_next;
        scan_word_reg   <= scan_word_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        out_granted_reg <= out_granted_next;
        out_status_reg  <= out_status_next;
    end

    // hint is either a real candidate id or the full marker, never id 0
    `LFIA_ASSERT(a_hint_range, clk, rst_n, (hint_reg <= CAP_POS) && (hint_reg != '0))
    // read-modify-write and scan never touch the same word in one cycle
    `LFIA_ASSERT(a_no_rw_clash, clk, rst_n, !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    // only a successful generate carries an id
    `LFIA_ASSERT(a_err_no_id, clk, rst_n, !rsp.valid || (rsp.status == ST_OK) || (rsp.granted_id == '0))
    // one request in flight
    `LFIA_ASSERT_NEXT(a_one_inflight, clk, rst_n, req.valid && req.ready, !req.ready)
    // a stalled result stays on offer
    `LFIA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid)
endmodule

// ===== dv/lowest_free_id_allocator_unit_tb.sv =====
module lowest_free_id_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfia_pkg::*;

    // Block geometry; the defaults are what the DUT is built with here.
    localparam int ID_CAP     = ID_CAPACITY_DEF;
    localparam int WORD_COUNT = (ID_CAPACITY_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;
    // Worst-case request latency: a full scan of the bitmap plus the pipeline.
    localparam int SCAN_CYCLES = WORD_COUNT + 4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int REPORT_MAX  = 10;

    // The one command code the package leaves out; the block must ignore it.
    localparam cmd_t CMD_SPARE = 2'd3;

    typedef struct packed {
        cmd_t       command;
        target_id_t target_id;
    } alloc_req_t;

    typedef struct packed {
        target_id_t granted_id;
        status_t    status;
    } alloc_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    lfia_req_if req ();
    lfia_rsp_if rsp ();

    lowest_free_id_allocator_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator shadow: one busy bit per id and the lowest-free hint.
    // ------------------------------------------------------------------
    logic [ID_CAP-1:0] id_busy;
    logic [10:0]       lowest_hint;

    alloc_req_t req_backlog[$];   // requests waiting for the driver
    alloc_rsp_t due_grants[$];    // results owed by the DUT, oldest first

    logic req_taken;              // request handshake seen at the last rising edge
    bit   idle_on;                // random gaps on both channels
    int   req_gap;
    int   rsp_gap;
    int   fail_count;
    int   cycle_count;

    // Move the hint to the next free id above it, or to capacity when none is left.
    function automatic logic [10:0] next_free_above(input logic [10:0] from);
        for (int i = from + 1; i < ID_CAP; i++)
        begin
            if (!id_busy[i])
                return 11'(i);
        end
        return 11'(ID_CAP);
    endfunction

    // Apply one accepted request to the shadow and work out the result it owes.
    task automatic predict_allocation(input alloc_req_t r, output alloc_rsp_t res);
        res.granted_id = '0;
        res.status     = ST_OK;
        case (r.command)
            CMD_GENERATE:
            begin
                if (lowest_hint >= ID_CAP)
                    res.status = ST_FULL;
                else
                begin
                    res.granted_id                       = lowest_hint[TARGET_W-1:0];
                    id_busy[lowest_hint[TARGET_W-1:0]]   = 1'b1;
                    lowest_hint                          = next_free_above(lowest_hint);
                end
            end
            CMD_FREE, CMD_REGISTER:
            begin
                // id 0 is reserved; with a 10-bit field nothing else is out of range
                if (r.target_id == '0 || int'(r.target_id) >= ID_CAP)
                    res.status = ST_BAD;
                else if (r.command == CMD_FREE)
                begin
                    if (r.target_id < lowest_hint)
                        lowest_hint = 11'(r.target_id);
                    id_busy[r.target_id] = 1'b0;
                end
                else
                begin
                    id_busy[r.target_id] = 1'b1;
                    if (11'(r.target_id) == lowest_hint)
                        lowest_hint = next_free_above(lowest_hint);
                end
            end
            default: ;  // spare code: no state change, plain ok
        endcase
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    // Half sit low, where the hint lives, the rest span the field; near_top first sends half to the top.
    function automatic target_id_t pick_target(input bit near_top);
        if (near_top && $urandom_range(0, 1) == 0)
            return target_id_t'($urandom_range(ID_CAP - 64, ID_CAP - 1));
        if ($urandom_range(0, 1) == 0)
            return target_id_t'($urandom_range(0, 63));
        return target_id_t'($urandom_range(0, ID_CAP - 1));
    endfunction

    // gen_pct: share of generates; the rest are frees, registers and the odd spare code.
    function automatic alloc_req_t pick_request(input int gen_pct, input bit near_top);
        alloc_req_t r;
        int         roll;
        roll        = $urandom_range(0, 99);
        r.target_id = pick_target(near_top);
        if (roll < gen_pct)
            r.command = CMD_GENERATE;
        else if (roll < gen_pct + (100 - gen_pct) / 2)
            r.command = CMD_FREE;
        else if (roll < 95)
            r.command = CMD_REGISTER;
        else
            r.command = CMD_SPARE;
        // generates ignore the target, so give it random bits anyway
        if (r.command == CMD_GENERATE)
            r.target_id = target_id_t'($urandom);
        return r;
    endfunction

    function automatic alloc_req_t mk_req(input cmd_t c, input int unsigned t);
        alloc_req_t r;
        r.command   = c;
        r.target_id = target_id_t'(t);
        return r;
    endfunction

    // Sender pause: nothing queued, nothing on the wire, nothing owed.
    // The #1 lets the edge's updates settle before looking.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (req_backlog.size() != 0 || req.valid || due_grants.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Request driver: changes at the falling edge, holds until taken.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : req_driver
        alloc_req_t nxt;
        if (!rst_n)
            req.valid <= 1'b0;
        else if (req.valid && !req_taken)
            ;  // still waiting for ready
        else if (req_gap > 0)
        begin
            req_gap   <= req_gap - 1;
            req.valid <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            // start a burst of idle cycles, this one included
            req_gap   <= $urandom_range(0, 10);
            req.valid <= 1'b0;
        end
        else if (req_backlog.size() != 0)
        begin
            nxt           = req_backlog.pop_front();
            req.valid     <= 1'b1;
            req.command   <= nxt.command;
            req.target_id <= nxt.target_id;
        end
        else
            req.valid <= 1'b0;
    end

    // Result back-pressure, in bursts of the same length.
    always @(negedge clk)
    begin : rsp_stall
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (rsp_gap > 0)
        begin
            rsp_gap   <= rsp_gap - 1;
            rsp.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rsp_gap   <= $urandom_range(0, 10);
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge.
    // Results are checked before the new request is predicted, so a stray
    // result can never pair up with a request taken on the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        alloc_req_t seen;
        alloc_rsp_t want;
        alloc_rsp_t owed;
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_grants.size() == 0)
                    note_failure($sformatf("unexpected result: granted_id=%0d status=%0d",
                                           rsp.granted_id, rsp.status));
                else
                begin
                    want = due_grants.pop_front();
                    if (rsp.granted_id !== want.granted_id || rsp.status !== want.status)
                        note_failure($sformatf(
                            "mismatch: granted_id exp %0d got %0d, status exp %0d got %0d",
                            want.granted_id, rsp.granted_id, want.status, rsp.status));
                end
            end
            if (req.valid && req.ready)
            begin
                seen.command   = req.command;
                seen.target_id = req.target_id;
                predict_allocation(seen, owed);
                due_grants.push_back(owed);
            end
            req_taken <= req.valid && req.ready;
        end
    end

    // Watchdog; generous against the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin : sequencer
        int free_ids;
        req.valid     = 1'b0;
        req.command   = CMD_GENERATE;
        req.target_id = '0;
        rsp.ready     = 1'b0;
        rst_n         = 1'b0;
        id_busy       = '0;
        lowest_hint   = 11'd1;
        idle_on       = 1'b1;
        req_gap       = 0;
        rsp_gap       = 0;
        fail_count    = 0;
        cycle_count   = 0;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed: hint walk, register on and off the hint, repeated frees and
        // registers, reserved id 0, the top id, the spare code, alternating bits.
        req_backlog.push_back(mk_req(CMD_GENERATE, 0));
        req_backlog.push_back(mk_req(CMD_GENERATE, 1023));
        req_backlog.push_back(mk_req(CMD_GENERATE, 0));
        req_backlog.push_back(mk_req(CMD_REGISTER, 5));     // above the hint
        req_backlog.push_back(mk_req(CMD_REGISTER, 4));     // on the hint, skips 5
        req_backlog.push_back(mk_req(CMD_GENERATE, 0));
        req_backlog.push_back(mk_req(CMD_FREE, 2));         // lowers the hint
        req_backlog.push_back(mk_req(CMD_FREE, 2));         // already free
        req_backlog.push_back(mk_req(CMD_REGISTER, 3));     // already used
        req_backlog.push_back(mk_req(CMD_FREE, 0));         // reserved id
        req_backlog.push_back(mk_req(CMD_REGISTER, 0));     // reserved id
        req_backlog.push_back(mk_req(CMD_FREE, 1023));      // free, above the hint
        req_backlog.push_back(mk_req(CMD_REGISTER, 1023));
        req_backlog.push_back(mk_req(CMD_REGISTER, 1023));
        req_backlog.push_back(mk_req(CMD_FREE, 1023));
        req_backlog.push_back(mk_req(CMD_SPARE, 1023));
        req_backlog.push_back(mk_req(CMD_SPARE, 0));
        req_backlog.push_back(mk_req(CMD_GENERATE, 0));
        req_backlog.push_back(mk_req(CMD_FREE, 1));
        req_backlog.push_back(mk_req(CMD_GENERATE, 0));
        req_backlog.push_back(mk_req(CMD_REGISTER, 682));
        req_backlog.push_back(mk_req(CMD_REGISTER, 341));
        req_backlog.push_back(mk_req(CMD_FREE, 682));
        req_backlog.push_back(mk_req(CMD_GENERATE, 0));
        wait_drained();

        // Mixed traffic, generate heavy so the bitmap fills; the first 80 with gaps, the other 70 without.
        repeat (80) req_backlog.push_back(pick_request(55, 1'b0));
        wait_drained();
        idle_on = 1'b0;
        repeat (70) req_backlog.push_back(pick_request(55, 1'b0));
        wait_drained();
        idle_on = 1'b1;

        // Fill to exhaustion: one generate per free id plus four more, so at least four
        // must report full, with random registers mixed in.
        free_ids = 0;
        for (int i = 1; i < ID_CAP; i++)
            free_ids += !id_busy[i];
        for (int i = 0; i < free_ids + 4; i++)
        begin
            req_backlog.push_back(mk_req(CMD_GENERATE, $urandom));
            if ($urandom_range(0, 31) == 0)
                req_backlog.push_back(mk_req(CMD_REGISTER, pick_target(1'b1)));
        end
        wait_drained();

        // Near full, no gaps: frees reopen ids, generates refill them.
        idle_on = 1'b0;
        req_backlog.push_back(mk_req(CMD_FREE, 1023));
        req_backlog.push_back(mk_req(CMD_REGISTER, 1023));  // on the hint, back to full
        req_backlog.push_back(mk_req(CMD_GENERATE, 0));
        repeat (60) req_backlog.push_back(pick_request(45, 1'b1));
        wait_drained();

        // Let any late or stray result show up.
        repeat (2 * SCAN_CYCLES) @(negedge clk);
        if (due_grants.size() != 0)
            note_failure($sformatf("%0d results never arrived", due_grants.size()));

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lfia_pkg.sv
hdl/lfia_req_if.sv
hdl/lfia_rsp_if.sv
hdl/lfia_ram.sv
hdl/lowest_free_id_allocator_unit.sv
dv/lowest_free_id_allocator_unit_tb.sv
